/* rtl/lsc_pkg.sv */
// Shared constants, types, keyword table and helper functions of the
// log line severity classifier. No dependencies.
package lsc_pkg;

  localparam int WINDOW_DEPTH  = 7;
  localparam int MAX_CHARS     = 511;
  localparam int CNT_W         = $clog2(MAX_CHARS + 1);
  localparam int KEYWORD_COUNT = 13;
  localparam int GROUP_COUNT   = 5;

  typedef logic [7:0]                     byte_t;
  typedef logic [2:0]                     sev_class_t;
  typedef logic [CNT_W-1:0]               count_t;
  typedef logic [GROUP_COUNT-1:0]         group_hits_t;
  typedef byte_t [WINDOW_DEPTH-1:0]       window_t;
  typedef logic [WINDOW_DEPTH*8-1:0]      kw_text_t;
  typedef logic [2:0]                     kw_len_t;
  typedef logic [2:0]                     kw_group_t;

  // Item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Severity classes, in priority order.
  localparam sev_class_t CLASS_ERROR   = 3'd0;
  localparam sev_class_t CLASS_WARNING = 3'd1;
  localparam sev_class_t CLASS_DEBUG   = 3'd2;
  localparam sev_class_t CLASS_SUCCESS = 3'd3;
  localparam sev_class_t CLASS_INFO    = 3'd4;
  localparam sev_class_t CLASS_NONE    = 3'd5;

  localparam count_t MAX_COUNT = count_t'(MAX_CHARS);

  // A string literal is right-justified, so byte i of an entry is the
  // character that must sit i places back from the newest byte.
  localparam kw_text_t KW_TEXT [KEYWORD_COUNT] = '{
    kw_text_t'("error"),   kw_text_t'("fail"),   kw_text_t'("fatal"),
    kw_text_t'("crit"),    kw_text_t'("warn"),   kw_text_t'("debug"),
    kw_text_t'("trace"),   kw_text_t'("ok"),     kw_text_t'("success"),
    kw_text_t'("start"),   kw_text_t'("listen"), kw_text_t'("info"),
    kw_text_t'("notice")
  };

  localparam kw_len_t KW_LEN [KEYWORD_COUNT] = '{
    3'd5, 3'd4, 3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd2, 3'd7, 3'd5, 3'd6, 3'd4, 3'd6
  };

  localparam kw_group_t KW_GROUP [KEYWORD_COUNT] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4
  };

  // Lowercase A-Z only; every other code passes unchanged.
  function automatic byte_t to_lower(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Lowest set group wins; no group set means no class.
  function automatic sev_class_t pick_class(input group_hits_t hits);
    sev_class_t r;
    r = CLASS_NONE;
    priority if (hits[0]) r = CLASS_ERROR;
    else if (hits[1]) r = CLASS_WARNING;
    else if (hits[2]) r = CLASS_DEBUG;
    else if (hits[3]) r = CLASS_SUCCESS;
    else if (hits[4]) r = CLASS_INFO;
    else r = CLASS_NONE;
    return r;
  endfunction

endpackage

/* rtl/lsc_text_if.sv */
// Input channel of the classifier: one byte or end-of-line per request.
// Depends on lsc_pkg.
interface lsc_text_if;
  import lsc_pkg::*;

  logic  valid;
  logic  ready;
  logic  kind;
  byte_t char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

/* rtl/lsc_class_if.sv */
// Output channel of the classifier: one severity class per request.
// Depends on lsc_pkg.
interface lsc_class_if;
  import lsc_pkg::*;

  logic       valid;
  logic       ready;
  sev_class_t severity_class;

  modport source (output valid, output severity_class, input ready);
  modport sink   (input valid, input severity_class, output ready);
endinterface

/* rtl/log_line_severity_classifier.sv */
// Log line severity classifier: one byte per request in, one class per line out.
// The class of a line is registered and becomes valid in the cycle after its end-of-line request.
// Throughput: one request per cycle; the input stalls only while the result
// register holds a class that the sink has not taken.
// Reset (synchronous, active high) empties the window, count, flags and result.
// Depends on lsc_pkg, lsc_text_if, lsc_class_if, lsc_cell and lsc_matcher.
module log_line_severity_classifier (
  input logic         clk,
  input logic         rst,
  lsc_text_if.sink    text,
  lsc_class_if.source result
);
  import lsc_pkg::*;

  // Request decode. A character counts only while the line has not been
  // stopped by a zero byte and the count is below the line limit.
  logic        in_fire;
  logic        eol;
  logic        open_char;
  logic        take;
  logic        stop_set;
  byte_t       lower;

  count_t      chars_seen;
  count_t      chars_seen_next;
  logic        stopped;
  logic        stopped_next;
  group_hits_t group_hits;
  group_hits_t group_hits_next;
  group_hits_t hits_now;

  logic        out_valid;
  sev_class_t  out_class;

  window_t     cell_q;
  window_t     window_next;

  // The result register parts the two sides: a new request enters whenever
  // the register is empty or is being emptied in the same cycle.
  assign text.ready = !out_valid || result.ready;
  assign in_fire    = text.valid && text.ready;
  assign eol        = in_fire && (text.kind == KIND_EOL);
  assign open_char  = in_fire && (text.kind == KIND_CHAR) && !stopped &&
                      (chars_seen < MAX_COUNT);
  assign take       = open_char && (text.char_byte != 8'h00);
  assign stop_set   = open_char && (text.char_byte == 8'h00);
  assign lower      = to_lower(text.char_byte);

  // The window is a chain of byte cells. On a counted byte every cell takes
  // its neighbor's byte and the first takes the new lowercased byte; an end
  // of line clears the whole chain back to zero.
  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign window_next[i] = lower;
    end else begin : g_body
      assign window_next[i] = cell_q[i-1];
    end
    lsc_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .clear (eol),
      .shift (take),
      .d     (window_next[i]),
      .q     (cell_q[i])
    );
  end

  // Keywords are matched against the window as it will stand after the
  // shift, so a hit is recorded in the same cycle as its last byte. Cells
  // that have not yet been filled on this line hold zero and never match,
  // which also covers keywords longer than the bytes seen so far.
  lsc_matcher u_matcher (
    .window (window_next),
    .hits   (hits_now)
  );

  always_comb begin
    chars_seen_next = chars_seen;
    stopped_next    = stopped;
    group_hits_next = group_hits;
    priority if (eol) begin
      chars_seen_next = '0;
      stopped_next    = 1'b0;
      group_hits_next = '0;
    end else if (take) begin
      chars_seen_next = chars_seen + count_t'(1);
      group_hits_next = group_hits | hits_now;
    end else if (stop_set) begin
      stopped_next    = 1'b1;
    end else begin
      chars_seen_next = chars_seen;
      stopped_next    = stopped;
      group_hits_next = group_hits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars_seen <= '0;
      stopped    <= 1'b0;
      group_hits <= '0;
    end else begin
      chars_seen <= chars_seen_next;
      stopped    <= stopped_next;
      group_hits <= group_hits_next;
    end
  end

  // Result register: loaded with the class of the finished line, held
  // until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (eol) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eol) begin
      out_class <= pick_class(group_hits);
    end
  end

  assign result.valid          = out_valid;
  assign result.severity_class = out_class;

  // The byte count never runs past the line limit.
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    chars_seen <= MAX_COUNT)
    else $error("byte count above line limit");

  // An end of line leaves a pending class and a fresh line state behind.
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    eol |=> (out_valid && group_hits == '0 && chars_seen == '0 && !stopped))
    else $error("end of line did not clear line state");

  // A stopped line records no further hits until it ends.
  a_stopped_frozen: assert property (@(posedge clk) disable iff (rst)
    (stopped && !eol) |=> ($stable(group_hits) && $stable(chars_seen)))
    else $error("stopped line changed its state");

  // A delivered class is always one of the defined codes.
  a_class_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_class <= CLASS_NONE))
    else $error("class code out of range");
endmodule

/* rtl/lsc_cell.sv */
// One byte cell of the recent-character window; cells form a shift chain.
// Depends on lsc_pkg.
module lsc_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic          shift,
  input  lsc_pkg::byte_t d,
  output lsc_pkg::byte_t q
);
  import lsc_pkg::*;

  byte_t held;

  // A cleared cell holds zero, which no keyword character matches.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      held <= '0;
    end else if (shift) begin
      held <= d;
    end
  end

  assign q = held;
endmodule

/* rtl/lsc_matcher.sv */
// Compares the window tail against every keyword and reports group hits.
// Depends on lsc_pkg.
module lsc_matcher (
  input  lsc_pkg::window_t     window,
  output lsc_pkg::group_hits_t hits
);
  import lsc_pkg::*;

  always_comb begin
    logic m;
    hits = '0;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      m = 1'b1;
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        if (kw_len_t'(i) < KW_LEN[k] && window[i] != KW_TEXT[k][i*8 +: 8]) begin
          m = 1'b0;
        end
      end
      if (m) begin
        hits[KW_GROUP[k]] = 1'b1;
      end
    end
  end
endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for log_line_severity_classifier: random text lines
// in, one severity class per line out, checked against an in-bench predictor.
// Depends on lsc_pkg, lsc_text_if, lsc_class_if and the classifier RTL.
module tb;
  import lsc_pkg::*;

  localparam int unsigned LINE_ITEMS  = 1300;    // input requests for the whole run
  localparam int unsigned CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int unsigned HOLD_CYCLES = 400;     // long receiver hold-off
  localparam int unsigned IDLE_PCT    = 38;

  // The scoreboard tracks one line of text exactly as the classifier should:
  // a seven-byte window of lowercased bytes, a saturating byte count, five
  // sticky group flags and a stop flag for zero bytes. An end-of-line request
  // turns the flags into a class, which waits in a queue for the DUT's answer.
  class severity_tracker;
    string       words[KEYWORD_COUNT];
    sev_class_t  word_class[KEYWORD_COUNT];
    byte_t       recent[WINDOW_DEPTH];
    int unsigned counted;
    bit [GROUP_COUNT-1:0] hits;
    bit          halted;
    sev_class_t  awaited[$];
    int unsigned mismatches;

    function new();
      words = '{"error", "fail", "fatal", "crit", "warn", "debug", "trace",
                "ok", "success", "start", "listen", "info", "notice"};
      word_class = '{CLASS_ERROR, CLASS_ERROR, CLASS_ERROR, CLASS_ERROR,
                     CLASS_WARNING, CLASS_DEBUG, CLASS_DEBUG,
                     CLASS_SUCCESS, CLASS_SUCCESS, CLASS_SUCCESS, CLASS_SUCCESS,
                     CLASS_INFO, CLASS_INFO};
      mismatches = 0;
      clear_line();
    endfunction

    function void clear_line();
      foreach (recent[i]) recent[i] = 8'h00;
      counted = 0;
      hits    = '0;
      halted  = 1'b0;
    endfunction

    function void note_request(logic kind, byte_t b);
      byte_t       c;
      sev_class_t  verdict;
      int unsigned len;
      bit          hit;
      if (kind == KIND_EOL) begin
        if (hits[CLASS_ERROR])        verdict = CLASS_ERROR;
        else if (hits[CLASS_WARNING]) verdict = CLASS_WARNING;
        else if (hits[CLASS_DEBUG])   verdict = CLASS_DEBUG;
        else if (hits[CLASS_SUCCESS]) verdict = CLASS_SUCCESS;
        else if (hits[CLASS_INFO])    verdict = CLASS_INFO;
        else                          verdict = CLASS_NONE;
        awaited.push_back(verdict);
        clear_line();
        return;
      end
      if (halted || counted >= MAX_CHARS) return;
      if (b == 8'h00) begin
        halted = 1'b1;
        return;
      end
      c = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = c;
      counted++;
      for (int k = 0; k < KEYWORD_COUNT; k++) begin
        len = words[k].len();
        if (len > WINDOW_DEPTH || counted < len) continue;
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (recent[i] != byte_t'(words[k][len-1-i])) hit = 1'b0;
        end
        if (hit) hits[word_class[k]] = 1'b1;
      end
    endfunction

    function void check_class(sev_class_t got);
      sev_class_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected severity_class %0d, none expected", $time, got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: severity_class mismatch: expected %0d, actual %0d",
                   $time, want, got);
        end
      end
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  lsc_text_if  text_ch ();
  lsc_class_if class_ch ();

  log_line_severity_classifier u_dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (class_ch)
  );

  severity_tracker tracker;

  int unsigned items_sent;     // every accepted input request
  int unsigned cycle_count;
  bit          calm;           // when set, neither side idles
  bit          hold_request;   // asks the receiver for one long hold-off

  // Free-running 8 ns clock.
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog. A correct run ends long before this count is reached.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Monitor. All inputs are driven with nonblocking assignments, so at the
  // edge both channels still show what was present just before it. An input
  // request updates the predicted line state; an output request is checked
  // against the oldest predicted class. The DUT answers no earlier than the
  // cycle after an end of line, so the order of the two tests does not matter.
  always @(posedge clk) begin
    if (!rst) begin
      if (text_ch.valid && text_ch.ready) begin
        tracker.note_request(text_ch.kind, text_ch.char_byte);
      end
      if (class_ch.valid && class_ch.ready) begin
        tracker.check_class(class_ch.severity_class);
      end
    end
  end

  // Receiver. Ready is redrawn every cycle: low about 38 times in a hundred,
  // always high during the calm stretch, and held low for HOLD_CYCLES once on
  // request so that the result register stays full and the DUT stalls its
  // input while the sender keeps offering bytes.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    class_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        class_ch.ready <= 1'b0;
      end else if (calm || rst) begin
        class_ch.ready <= !rst;
      end else begin
        class_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request and returns once it has been taken. Random idle
  // cycles go in front of it; when none are drawn, valid simply stays high
  // from the previous request, so it is never lowered and raised in one step.
  task automatic offer_request(input logic kind, input byte_t b);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        text_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    text_ch.valid     <= 1'b1;
    text_ch.kind      <= kind;
    text_ch.char_byte <= b;
    do @(posedge clk); while (!text_ch.ready);
    items_sent++;
  endtask

  // Drops valid and waits until every predicted class has come back.
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (tracker.outstanding() != 0);
  endtask

  // Ordinary text: letters, digits and spaces in random case.
  function automatic byte_t filler_byte();
    case ($urandom_range(3))
      0:       return byte_t'(8'h61 + $urandom_range(25));
      1:       return byte_t'(8'h41 + $urandom_range(25));
      2:       return 8'h20;
      default: return byte_t'(8'h30 + $urandom_range(9));
    endcase
  endfunction

  // Sends keyword k in random case, optionally cut short by one letter so
  // that near misses also occur.
  task automatic send_keyword(input int unsigned k, input bit cut_short);
    int unsigned len;
    byte_t       c;
    len = tracker.words[k].len() - (cut_short ? 1 : 0);
    for (int i = 0; i < len; i++) begin
      c = byte_t'(tracker.words[k][i]);
      if ($urandom_range(1)) c -= 8'h20;
      offer_request(KIND_CHAR, c);
    end
  endtask

  // Sends a short line. Most of it is keywords and plain text so that the
  // group flags and their priority get a real workout; raw bytes cover every
  // code including the high half, and a zero byte now and then cuts the line.
  task automatic send_random_line();
    int unsigned pick;
    repeat ($urandom_range(0, 4)) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_keyword($urandom_range(KEYWORD_COUNT - 1), $urandom_range(9) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) offer_request(KIND_CHAR, filler_byte());
      end else if (pick < 95) begin
        offer_request(KIND_CHAR, byte_t'($urandom_range(1, 255)));
      end else begin
        offer_request(KIND_CHAR, 8'h00);
      end
    end
    offer_request(KIND_EOL, byte_t'($urandom_range(255)));
  endtask

  // Sends a line that reaches close to or past the counted limit, with a keyword that ends
  // just before, on or after the last counted byte. The padding is digits
  // and spaces so that only the keyword can set a flag.
  task automatic send_long_line();
    repeat (MAX_CHARS - 6 + $urandom_range(0, 8)) begin
      offer_request(KIND_CHAR, $urandom_range(1) ? 8'h20 : byte_t'(8'h30 + $urandom_range(9)));
    end
    send_keyword($urandom_range(KEYWORD_COUNT - 1), 1'b0);
    repeat ($urandom_range(0, 5)) offer_request(KIND_CHAR, filler_byte());
    offer_request(KIND_EOL, 8'h00);
  endtask

  // Stimulus.
  initial begin
    int unsigned line_no;
    tracker      = new();
    items_sent   = 0;
    calm         = 1'b0;
    hold_request = 1'b0;
    rst               <= 1'b1;
    text_ch.valid     <= 1'b0;
    text_ch.kind      <= KIND_CHAR;
    text_ch.char_byte <= 8'h00;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed lines. An empty line whose end-of-line request carries an
    // all-ones byte that must be ignored.
    offer_request(KIND_EOL, 8'hFF);
    // The shortest keyword in mixed case.
    offer_request(KIND_CHAR, 8'h4F);
    offer_request(KIND_CHAR, 8'h6B);
    offer_request(KIND_EOL, 8'h00);
    // A single byte: too few bytes for any keyword.
    offer_request(KIND_CHAR, 8'h6B);
    offer_request(KIND_EOL, 8'h00);
    // Upper-case warning keyword.
    offer_request(KIND_CHAR, 8'h57);
    offer_request(KIND_CHAR, 8'h41);
    offer_request(KIND_CHAR, 8'h52);
    offer_request(KIND_CHAR, 8'h4E);
    offer_request(KIND_EOL, 8'h55);
    // A zero byte in front of a keyword stops matching for the whole line.
    offer_request(KIND_CHAR, 8'h78);
    offer_request(KIND_CHAR, 8'h00);
    offer_request(KIND_CHAR, 8'h6F);
    offer_request(KIND_CHAR, 8'h6B);
    offer_request(KIND_EOL, 8'h00);
    // Info followed by an error keyword: the error group takes priority.
    offer_request(KIND_CHAR, 8'h69);
    offer_request(KIND_CHAR, 8'h6E);
    offer_request(KIND_CHAR, 8'h66);
    offer_request(KIND_CHAR, 8'h6F);
    offer_request(KIND_CHAR, 8'h46);
    offer_request(KIND_CHAR, 8'h41);
    offer_request(KIND_CHAR, 8'h49);
    offer_request(KIND_CHAR, 8'h4C);
    offer_request(KIND_EOL, 8'h80);

    // Random lines. Along the way: one over-long line, one pause until
    // every class has returned, one long receiver hold-off while bytes keep
    // coming, and a stretch in which neither side idles.
    line_no = 0;
    while (items_sent < LINE_ITEMS) begin
      if (line_no == 20) drain_results();
      if (line_no == 30) hold_request = 1'b1;
      calm = (line_no >= 40 && line_no < 70);
      if (line_no == 10) begin
        send_long_line();
      end else begin
        send_random_line();
      end
      line_no++;
    end
    calm = 1'b0;

    // Wait for the last classes, and then for anything stray.
    drain_results();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
